// ===== hdl/cavlc_nc_context_defines.svh =====
// ----------------------------------------------------------------------------
// CAVLC nC context assertion macros
// Shared concurrent assertion forms used by the checker of the nC context block.
// ----------------------------------------------------------------------------
`ifndef CAVLC_NC_CONTEXT_DEFINES_SVH
`define CAVLC_NC_CONTEXT_DEFINES_SVH

// Same-cycle implication, muted while reset is held
`define CNC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cavlc_nc_context: same-cycle check failed");

// Next-cycle implication, muted while reset is held
`define CNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cavlc_nc_context: next-cycle check failed");

`endif

// ===== hdl/cnc_pkg.sv =====
// ----------------------------------------------------------------------------
// CAVLC nC context package
// Operation and block type codes, neighbour source tables and shared types.
// ----------------------------------------------------------------------------
package cnc_pkg;

    // Field widths
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 5;
    localparam int NC_W   = 6;
    localparam int REG_W  = 32;

    // Count store layout: 16 luma, 4 Cb, 4 Cr
    localparam int STORE_DEPTH = 24;
    localparam logic [ADDR_W-1:0] CHROMA_BASE = 5'd16;
    localparam logic [ADDR_W-1:0] CR_OFFSET   = 5'd4;
    localparam logic [ADDR_W-1:0] CHROMA_LAST = 5'd7;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Block type codes
    localparam logic [1:0] TYPE_LUMA_DC   = 2'd0;
    localparam logic [1:0] TYPE_LUMA_AC   = 2'd1;
    localparam logic [1:0] TYPE_CHROMA_DC = 2'd2;
    localparam logic [1:0] TYPE_CHROMA_AC = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_LEFT_LUMA = 2'd0;
    localparam logic [1:0] REG_TOP_LUMA  = 2'd1;
    localparam logic [1:0] REG_NB_CB     = 2'd2;
    localparam logic [1:0] REG_NB_CR     = 2'd3;

    // Chroma DC blocks have no context
    localparam logic signed [NC_W-1:0] NC_CHROMA_DC = -6'sd1;

    // Neighbour selection for one query, decided at acceptance
    typedef struct packed {
        logic       dc;      // chroma DC, fixed result
        logic       chroma;  // chroma AC, use chroma neighbour registers
        logic       cr;      // Cr plane rather than Cb
        logic       a_reg;   // A comes from a neighbour register lane
        logic [1:0] a_lane;
        logic       b_reg;   // B comes from a neighbour register lane
        logic [1:0] b_lane;
        logic       la;      // A available
        logic       ta;      // B available
    } t_pick;

    // Left (A) source of a luma block: bit 4 set selects a left register lane
    function automatic logic [4:0] luma_a_src(input logic [3:0] blk);
        logic [4:0] code;
        case (blk)
            4'd0:    code = 5'h13;
            4'd1:    code = 5'd0;
            4'd2:    code = 5'h12;
            4'd3:    code = 5'd2;
            4'd4:    code = 5'd1;
            4'd5:    code = 5'd4;
            4'd6:    code = 5'd3;
            4'd7:    code = 5'd6;
            4'd8:    code = 5'h11;
            4'd9:    code = 5'd8;
            4'd10:   code = 5'h10;
            4'd11:   code = 5'd10;
            4'd12:   code = 5'd9;
            4'd13:   code = 5'd12;
            4'd14:   code = 5'd11;
            default: code = 5'd14;
        endcase
        return code;
    endfunction

    // Top (B) source of a luma block: bit 4 set selects a top register lane
    function automatic logic [4:0] luma_b_src(input logic [3:0] blk);
        logic [4:0] code;
        case (blk)
            4'd0:    code = 5'h13;
            4'd1:    code = 5'h12;
            4'd2:    code = 5'd0;
            4'd3:    code = 5'd1;
            4'd4:    code = 5'h11;
            4'd5:    code = 5'h10;
            4'd6:    code = 5'd4;
            4'd7:    code = 5'd5;
            4'd8:    code = 5'd2;
            4'd9:    code = 5'd3;
            4'd10:   code = 5'd8;
            4'd11:   code = 5'd9;
            4'd12:   code = 5'd6;
            4'd13:   code = 5'd7;
            4'd14:   code = 5'd12;
            default: code = 5'd13;
        endcase
        return code;
    endfunction

    // Low count bits of one 8-bit lane
    function automatic logic [CNT_W-1:0] lane_of(input logic [REG_W-1:0] word,
                                                 input logic [1:0] lane);
        logic [CNT_W-1:0] cnt;
        case (lane)
            2'd0:    cnt = word[4:0];
            2'd1:    cnt = word[12:8];
            2'd2:    cnt = word[20:16];
            default: cnt = word[28:24];
        endcase
        return cnt;
    endfunction

endpackage

// ===== hdl/cavlc_nc_context.sv =====
// ----------------------------------------------------------------------------
// CAVLC nC context store and derivation
// Keeps the total-coefficient counts of the current macroblock's 16 luma and
// 8 chroma 4x4 blocks and derives the nC context of a block from its left and
// top neighbours. A transaction can be accepted every cycle; the input stalls
// only while a query waits behind a result that has not been taken. Clear and
// write transactions take effect at the accepting edge and give no result. The
// accepting edge of a query registers the count store read (two read ports,
// one write port) into stage one; from there the neighbour selection and
// rounded mean go into the output register once it is free. A query may
// directly follow a write or clear and sees its effect. Neighbour registers are
// to be written through the configuration channel only while no query is in
// flight; the user is bound to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cavlc_nc_context (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic [1:0]         i_block_type,
    input  logic [3:0]         i_block_index,
    input  logic               i_left_mb_available,
    input  logic               i_top_mb_available,
    input  logic [4:0]         i_coeff_count,
    // result transactions
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [5:0]  o_nc_value,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int CW = cnc_pkg::CNT_W;
    localparam int AW = cnc_pkg::ADDR_W;

    // Configuration registers
    logic [cnc_pkg::REG_W-1:0] r_left_luma;
    logic [cnc_pkg::REG_W-1:0] r_top_luma;
    logic [cnc_pkg::REG_W-1:0] r_nb_cb;
    logic [cnc_pkg::REG_W-1:0] r_nb_cr;

    // Count store with per-entry valid bits
    logic [CW-1:0]                   r_mem [cnc_pkg::STORE_DEPTH];
    logic [cnc_pkg::STORE_DEPTH-1:0] r_valid;

    // Pipeline control
    logic r_s1_valid, n_s1_valid;
    logic r_out_valid, n_out_valid;
    logic s1_adv;
    logic in_accept;

    // Stage one payload
    cnc_pkg::t_pick r_pick;
    logic [CW-1:0]  r_a_mem, r_b_mem;
    logic           r_a_vld, r_b_vld;

    // Acceptance side decode
    cnc_pkg::t_pick pick;
    logic [AW-1:0]  rd_a, rd_b, wr_addr, chroma_base;
    logic [4:0]     src_a, src_b;
    logic [3:0]     luma_blk;

    // Result side
    logic [cnc_pkg::REG_W-1:0]          reg_a, reg_b;
    logic [CW-1:0]                      na, nb;
    logic [CW:0]                        sum;
    logic signed [cnc_pkg::NC_W-1:0]    nc;
    logic signed [cnc_pkg::NC_W-1:0]    r_nc;

    // Handshake
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_nc_value  = r_nc;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_luma <= '0;
            r_top_luma  <= '0;
            r_nb_cb     <= '0;
            r_nb_cr     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cnc_pkg::REG_LEFT_LUMA: r_left_luma <= i_cfg_data;
                cnc_pkg::REG_TOP_LUMA:  r_top_luma  <= i_cfg_data;
                cnc_pkg::REG_NB_CB:     r_nb_cb     <= i_cfg_data;
                cnc_pkg::REG_NB_CR:     r_nb_cr     <= i_cfg_data;
                default:                r_nb_cr     <= r_nb_cr;
            endcase
        end
    end

    // Decode neighbour sources and store addresses of the incoming query
    always_comb begin
        pick        = '0;
        rd_a        = '0;
        rd_b        = '0;
        luma_blk    = (i_block_type == cnc_pkg::TYPE_LUMA_DC) ? 4'd0 : i_block_index;
        src_a       = cnc_pkg::luma_a_src(luma_blk);
        src_b       = cnc_pkg::luma_b_src(luma_blk);
        chroma_base = cnc_pkg::CHROMA_BASE
                      + ((i_block_index < 4'd4) ? '0 : cnc_pkg::CR_OFFSET);
        case (i_block_type)
            cnc_pkg::TYPE_CHROMA_DC: begin
                pick.dc = 1'b1;
            end
            cnc_pkg::TYPE_CHROMA_AC: begin
                pick.chroma = 1'b1;
                pick.cr     = (i_block_index >= 4'd4);
                case (i_block_index[1:0])
                    2'd0: begin
                        pick.a_reg  = 1'b1;
                        pick.a_lane = 2'd1;
                        pick.b_reg  = 1'b1;
                        pick.b_lane = 2'd3;
                    end
                    2'd1: begin
                        rd_a        = chroma_base;
                        pick.b_reg  = 1'b1;
                        pick.b_lane = 2'd2;
                    end
                    2'd2: begin
                        pick.a_reg  = 1'b1;
                        pick.a_lane = 2'd0;
                        rd_b        = chroma_base;
                    end
                    default: begin
                        rd_a = chroma_base + 5'd2;
                        rd_b = chroma_base + 5'd1;
                    end
                endcase
            end
            default: begin
                pick.a_reg  = src_a[4];
                pick.a_lane = src_a[1:0];
                pick.b_reg  = src_b[4];
                pick.b_lane = src_b[1:0];
                rd_a        = {1'b0, src_a[3:0]};
                rd_b        = {1'b0, src_b[3:0]};
            end
        endcase
        pick.la = pick.a_reg ? i_left_mb_available : 1'b1;
        pick.ta = pick.b_reg ? i_top_mb_available : 1'b1;
    end

    // Write address: luma AC to luma entries, anything else to chroma entries
    assign wr_addr = (i_block_type == cnc_pkg::TYPE_LUMA_AC) ? {1'b0, i_block_index}
                   : cnc_pkg::CHROMA_BASE
                     + (i_block_index[3] ? cnc_pkg::CHROMA_LAST
                                         : {2'b00, i_block_index[2:0]});

    // Store write and registered reads
    always_ff @(posedge i_clk) begin
        if (in_accept && i_operation == cnc_pkg::OP_WRITE) begin
            r_mem[wr_addr] <= i_coeff_count;
        end
        if (in_accept && i_operation == cnc_pkg::OP_QUERY) begin
            r_a_mem <= r_mem[rd_a];
            r_b_mem <= r_mem[rd_b];
            r_a_vld <= r_valid[rd_a];
            r_b_vld <= r_valid[rd_b];
            r_pick  <= pick;
        end
    end

    // Clear or mark store entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (in_accept && i_operation == cnc_pkg::OP_CLEAR) begin
            r_valid <= '0;
        end else if (in_accept && i_operation == cnc_pkg::OP_WRITE) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Advance queries through stage one and the output register
    always_comb begin
        n_s1_valid  = (in_accept && i_operation == cnc_pkg::OP_QUERY)
                      || (r_s1_valid && !s1_adv);
        n_out_valid = s1_adv ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Select neighbour counts and form nC
    always_comb begin
        reg_a = !r_pick.chroma ? r_left_luma : (r_pick.cr ? r_nb_cr : r_nb_cb);
        reg_b = !r_pick.chroma ? r_top_luma  : (r_pick.cr ? r_nb_cr : r_nb_cb);
        na    = r_pick.a_reg ? cnc_pkg::lane_of(reg_a, r_pick.a_lane)
                             : (r_a_vld ? r_a_mem : '0);
        nb    = r_pick.b_reg ? cnc_pkg::lane_of(reg_b, r_pick.b_lane)
                             : (r_b_vld ? r_b_mem : '0);
        sum   = {1'b0, na} + {1'b0, nb} + 6'd1;
        if (r_pick.dc) begin
            nc = cnc_pkg::NC_CHROMA_DC;
        end else if (r_pick.la && r_pick.ta) begin
            nc = $signed({1'b0, sum[CW:1]});
        end else if (r_pick.la) begin
            nc = $signed({1'b0, na});
        end else if (r_pick.ta) begin
            nc = $signed({1'b0, nb});
        end else begin
            nc = '0;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_nc <= nc;
        end
    end

endmodule

// ===== hdl/cnc_checker.sv =====
// ----------------------------------------------------------------------------
// CAVLC nC context port checker
// Watches the ports of the nC context block for handshake and range slips.
// ----------------------------------------------------------------------------
`include "cavlc_nc_context_defines.svh"

module cnc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic signed [5:0] o_nc_value
);

    // Hold a stalled result
    `CNC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Keep a stalled result's value
    `CNC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_nc_value))

    // Back-pressure only comes from a result that is held at the output
    `CNC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    // nC is the chroma DC marker or a non-negative value
    `CNC_ASSERT_NOW(a_nc_range, i_clk, i_rst_n, o_out_valid, !o_nc_value[5] || o_nc_value == cnc_pkg::NC_CHROMA_DC)

endmodule

bind cavlc_nc_context cnc_checker u_cnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_nc_value  (o_nc_value)
);
